>>> design/krt_pkg.sv
// Shared types and codes for the keyed record table.
package krt_pkg;

    localparam int KEY_W  = 31;
    localparam int AMT_W  = 31;
    localparam int GRP_W  = 16;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
        logic [GRP_W-1:0] group;
    } rec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_READ
    } state_t;

endpackage

>>> design/krt_mem.sv
// Record RAM: one write port, one read port with registered read data.
module krt_mem #(
    parameter int TABLE_DEPTH = 1024,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic              clk,
    input  krt_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  krt_pkg::rec_t     wr_data,
    output krt_pkg::rec_t     rd_data
);
    import krt_pkg::*;

    rec_t mem [TABLE_DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/krt_ctrl.sv
// Sequencer with the shared scan pointer and key comparator of the record table.
module krt_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [krt_pkg::KIND_W-1:0]   kind,
    input  logic [krt_pkg::KEY_W-1:0]    key,
    input  logic [krt_pkg::AMT_W-1:0]    amount,
    input  logic [krt_pkg::GRP_W-1:0]    group,
    output logic                         busy,
    output logic                         done,
    output logic [krt_pkg::STAT_W-1:0]   status,
    output logic [krt_pkg::KEY_W-1:0]    record_key,
    output logic [krt_pkg::AMT_W-1:0]    record_amount,
    output logic [krt_pkg::GRP_W-1:0]    record_group,
    output logic [CW-1:0]                entry_count,
    output krt_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                rd_addr,
    output logic [AW-1:0]                wr_addr,
    output krt_pkg::rec_t                wr_data,
    input  krt_pkg::rec_t                rd_data
);
    import krt_pkg::*;

    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    state_t             state_reg, state_next;
    logic [KIND_W-1:0]  op_kind_reg;
    rec_t               op_rec_reg;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      lag_reg, lag_next;
    logic               vld_reg, vld_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [KEY_W-1:0]   nk_reg, nk_next;
    logic               done_reg, done_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    rec_t               res_reg, res_next;

    logic               accept;
    logic               hit;
    logic               more;
    logic               full;
    logic               empty;
    logic               pos_out;

    assign accept  = start && (state_reg == ST_IDLE);
    assign hit     = vld_reg && (rd_data.key == op_rec_reg.key);
    assign more    = ptr_reg < fill_reg;
    assign full    = fill_reg == FULL_COUNT;
    assign empty   = fill_reg == '0;
    assign pos_out = key >= KEY_W'(fill_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind) inside
                        KIND_UPDATE: state_next = ST_SEARCH;
                        KIND_DELETE: state_next = empty ? ST_IDLE : ST_SEARCH;
                        KIND_READ:   state_next = (empty || pos_out) ? ST_IDLE : ST_READ;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = (op_kind_reg == KIND_DELETE) ? ST_SHIFT : ST_IDLE;
                end
                else if (!more && !vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (!more && !vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mem_ctl     = '0;
        rd_addr     = ptr_reg[AW-1:0];
        wr_addr     = lag_reg[AW-1:0];
        wr_data     = rd_data;
        ptr_next    = ptr_reg;
        lag_next    = lag_reg;
        vld_next    = 1'b0;
        fill_next   = fill_reg;
        nk_next     = nk_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ptr_next = '0;
                    unique case (kind) inside
                        KIND_LOAD, KIND_ADD:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                                res_next    = '0;
                            end
                            else
                            begin
                                wr_addr        = fill_reg[AW-1:0];
                                wr_data.key    = (kind == KIND_ADD) ? nk_reg + KEY_W'(1) : key;
                                wr_data.amount = amount;
                                wr_data.group  = group;
                                mem_ctl.wr_en  = 1'b1;
                                fill_next      = fill_reg + ONE;
                                nk_next        = (kind == KIND_ADD) ? nk_reg + KEY_W'(1)
                                                                    : KEY_W'(fill_reg + ONE);
                                status_next    = STAT_OK;
                                res_next       = wr_data;
                            end
                        end
                        KIND_UPDATE:
                        begin
                        end
                        KIND_DELETE:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                status_next = STAT_EMPTY;
                                res_next    = '0;
                            end
                        end
                        KIND_READ:
                        begin
                            if (empty || pos_out)
                            begin
                                done_next   = 1'b1;
                                status_next = empty ? STAT_EMPTY : STAT_MISS;
                                res_next    = '0;
                            end
                            else
                            begin
                                rd_addr       = key[AW-1:0];
                                mem_ctl.rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = STAT_OK;
                            res_next    = '0;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    if (op_kind_reg == KIND_DELETE)
                    begin
                        // hold the removed record until the gap is closed
                        res_next = rd_data;
                    end
                    else
                    begin
                        wr_data       = op_rec_reg;
                        mem_ctl.wr_en = 1'b1;
                        done_next     = 1'b1;
                        status_next   = STAT_OK;
                        res_next      = op_rec_reg;
                    end
                end
                else if (more)
                begin
                    // compare the previous entry while fetching the next
                    mem_ctl.rd_en = 1'b1;
                    lag_next      = ptr_reg;
                    ptr_next      = ptr_reg + ONE;
                    vld_next      = 1'b1;
                end
                else if (!vld_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STAT_MISS;
                    res_next    = '0;
                end
            end
            ST_SHIFT:
            begin
                mem_ctl.wr_en = vld_reg;
                if (more)
                begin
                    // move entry ptr down to ptr - 1 in the next cycle
                    mem_ctl.rd_en = 1'b1;
                    lag_next      = ptr_reg - ONE;
                    ptr_next      = ptr_reg + ONE;
                    vld_next      = 1'b1;
                end
                else if (!vld_reg)
                begin
                    fill_next   = fill_reg - ONE;
                    done_next   = 1'b1;
                    status_next = STAT_OK;
                end
            end
            ST_READ:
            begin
                done_next   = 1'b1;
                status_next = STAT_OK;
                res_next    = rd_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vld_reg    <= 1'b0;
            fill_reg   <= '0;
            nk_reg     <= '0;
            done_reg   <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            vld_reg    <= vld_next;
            fill_reg   <= fill_next;
            nk_reg     <= nk_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_kind_reg       <= kind;
            op_rec_reg.key    <= key;
            op_rec_reg.amount <= amount;
            op_rec_reg.group  <= group;
        end
        ptr_reg <= ptr_next;
        lag_reg <= lag_next;
        res_reg <= res_next;
    end

    assign busy          = state_reg != ST_IDLE;
    assign done          = done_reg;
    assign status        = status_reg;
    assign record_key    = res_reg.key;
    assign record_amount = res_reg.amount;
    assign record_group  = res_reg.group;
    assign entry_count   = fill_reg;

endmodule

>>> design/keyed_record_table.sv
// Top level of the keyed record table: sequencer plus record RAM.
//
// Commands: drive kind, key, amount and group and raise start; the item is
// taken at a rising edge with start high and busy low. Each item gives one
// result on status, record_key, record_amount, record_group and entry_count,
// valid for the single cycle in which done is high. The receiver cannot
// stall; results must be taken when done is high.
// After the accepting edge, load, add, unused kinds and any item rejected
// up front (full, empty, read out of range) finish in the next cycle;
// read passes through the READ state for its registered RAM data. Update
// scans the table one entry a cycle through the single RAM read port and
// the shared key comparator, ending at the first match or, on a miss,
// after the last entry. Delete scans the same way, then moves each later
// entry down one a cycle.
// busy is low again in the cycle done is high, so the next item may start
// then. Reset empties the table and clears the key counter at once; no
// clearing pass runs, and RAM contents past entry_count are never read.
module keyed_record_table #(
    parameter int TABLE_DEPTH = 1024,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [krt_pkg::KIND_W-1:0]   kind,
    input  logic [krt_pkg::KEY_W-1:0]    key,
    input  logic [krt_pkg::AMT_W-1:0]    amount,
    input  logic [krt_pkg::GRP_W-1:0]    group,
    output logic                         done,
    output logic [krt_pkg::STAT_W-1:0]   status,
    output logic [krt_pkg::KEY_W-1:0]    record_key,
    output logic [krt_pkg::AMT_W-1:0]    record_amount,
    output logic [krt_pkg::GRP_W-1:0]    record_group,
    output logic [CW-1:0]                entry_count
);
    import krt_pkg::*;

    mem_ctl_t       mem_ctl;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    rec_t           wr_data;
    rec_t           rd_data;

    krt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .key           (key),
        .amount        (amount),
        .group         (group),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .record_key    (record_key),
        .record_amount (record_amount),
        .record_group  (record_group),
        .entry_count   (entry_count),
        .mem_ctl       (mem_ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_data       (rd_data)
    );

    krt_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // the count moves only with a result
    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(entry_count) |-> done)
        else $error("entry count changed without a result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> (entry_count == CW'(TABLE_DEPTH)))
        else $error("full status below table depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |->
            (record_key == '0 && record_amount == '0 && record_group == '0))
        else $error("failed item carries record data");

endmodule
